// ----- rtl/lr_pkg.sv -----
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer: coordinate and error
// widths, the request kinds and the command record passed to the back end.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int COLOR_BITS  = 32;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic
    {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_kind_t;

    // One classified request, with the line setup already worked out.
    typedef struct packed
    {
        req_kind_t kind;
        coord_t    sx;
        coord_t    sy;
        coord_t    ex;
        coord_t    ey;
        coord_t    dx;
        coord_t    dy;
        logic      sx_neg;
        logic      sy_neg;
        err_t      err;
    } cmd_t;

endpackage

// ----- rtl/line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line rasterizer: start requests load a line and emit its first
// pixel, step requests emit the next pixel, each pixel tagged with the configured color.
// Path: a request accepted into the command queue is carried out by the
// back-end update, which registers its pixel beat.
// Throughput: one request per cycle while neither the queue nor the pixel output stalls.
// Reset: no line in progress, empty queue, color register all ones.
// ----------------------------------------------------------------------------
module line_rasterizer_unit
    import lr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_stall,
    input  logic   req_type,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  color_t cfg_data
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign req_stall = q_full;
    assign cfg_ready = 1'b1;

    lr_front u_front
    (
        .req_type (req_type),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .cmd      (front_cmd)
    );

    lr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (req_valid && !q_full),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    lr_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (!q_empty),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last)
    );

endmodule

// ----- rtl/lr_front.sv -----
// ----------------------------------------------------------------------------
// lr_front
// Classifies each request and, for a start, computes the absolute deltas,
// step directions and initial error term of the new line.
// ----------------------------------------------------------------------------
module lr_front
    import lr_pkg::*;
(
    input  logic   req_type,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    output cmd_t   cmd
);

    coord_t dx;
    coord_t dy;

    assign dx = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
    assign dy = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);

    always_comb
    begin
        cmd.kind   = req_type ? REQ_STEP : REQ_START;
        cmd.sx     = start_x;
        cmd.sy     = start_y;
        cmd.ex     = end_x;
        cmd.ey     = end_y;
        cmd.dx     = dx;
        cmd.dy     = dy;
        cmd.sx_neg = !(start_x < end_x);
        cmd.sy_neg = !(start_y < end_y);
        cmd.err    = $signed({2'b00, dx}) - $signed({2'b00, dy});
    end

endmodule

// ----- rtl/lr_queue.sv -----
// ----------------------------------------------------------------------------
// lr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lr_queue
    import lr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/lr_back.sv -----
// ----------------------------------------------------------------------------
// lr_back
// Holds the line state and the color register, carries out one command per
// cycle while the output is not stalled and registers the resulting pixel beat.
// ----------------------------------------------------------------------------
module lr_back
    import lr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_avail,
    input  cmd_t   cmd,
    output logic   cmd_pop,
    input  logic   cfg_write,
    input  color_t cfg_data,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last
);

    color_t color_reg;
    coord_t cur_x_reg,  cur_x_next;
    coord_t cur_y_reg,  cur_y_next;
    coord_t tgt_x_reg,  tgt_x_next;
    coord_t tgt_y_reg,  tgt_y_next;
    coord_t dx_reg,     dx_next;
    coord_t dy_reg,     dy_next;
    logic   sx_neg_reg, sx_neg_next;
    logic   sy_neg_reg, sy_neg_next;
    err_t   err_reg,    err_next;
    logic   active_reg, active_next;
    logic   out_valid_reg;
    coord_t out_x_reg;
    coord_t out_y_reg;
    color_t out_color_reg;
    logic   out_last_reg;

    logic                       out_free;
    logic                       emit;
    logic                       is_last;
    logic                       move_x;
    logic                       move_y;
    logic signed [ERR_BITS:0]   e2;

    assign out_free = !out_valid_reg || !pixel_stall;
    assign cmd_pop  = cmd_avail && out_free;

    assign e2     = {err_reg, 1'b0};
    assign move_x = e2 > -$signed({3'b000, dy_reg});
    assign move_y = e2 < $signed({3'b000, dx_reg});

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;
        emit        = 1'b0;

        if (cmd_pop)
        begin
            case (cmd.kind)
                REQ_START:
                begin
                    cur_x_next  = cmd.sx;
                    cur_y_next  = cmd.sy;
                    tgt_x_next  = cmd.ex;
                    tgt_y_next  = cmd.ey;
                    dx_next     = cmd.dx;
                    dy_next     = cmd.dy;
                    sx_neg_next = cmd.sx_neg;
                    sy_neg_next = cmd.sy_neg;
                    err_next    = cmd.err;
                    emit        = 1'b1;
                end
                REQ_STEP:
                begin
                    // A step with no line in progress is dropped silently.
                    if (active_reg)
                    begin
                        emit     = 1'b1;
                        err_next = err_reg
                                 - (move_x ? $signed({2'b00, dy_reg}) : err_t'(0))
                                 + (move_y ? $signed({2'b00, dx_reg}) : err_t'(0));
                        if (move_x)
                        begin
                            cur_x_next = sx_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        end
                        if (move_y)
                        begin
                            cur_y_next = sy_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        is_last     = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        active_next = emit ? !is_last : active_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            sx_neg_reg    <= 1'b0;
            sy_neg_reg    <= 1'b0;
            err_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                color_reg <= cfg_data;
            end
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            sx_neg_reg <= sx_neg_next;
            sy_neg_reg <= sy_neg_next;
            err_reg    <= err_next;
            active_reg <= active_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= cur_x_next;
            out_y_reg     <= cur_y_next;
            out_color_reg <= color_reg;
            out_last_reg  <= is_last;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last        = out_last_reg;

endmodule
